FILE: rtl/core/mtwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_pkg
// Shared types, constants and word functions of the MT19937 word generator.
// ----------------------------------------------------------------------------
package mtwg_pkg;

    localparam int unsigned N_WORDS = 624;
    localparam int unsigned M_SHIFT = 397;
    localparam int unsigned ADDR_W  = $clog2(N_WORDS);
    localparam int unsigned WORD_W  = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;

    // The pointer runs from 0 up to N_WORDS, where it asks for a twist.
    localparam addr_t PTR_END   = addr_t'(N_WORDS);
    localparam addr_t LAST_ADDR = addr_t'(N_WORDS - 1);
    localparam addr_t FAR_STEP  = addr_t'(M_SHIFT);
    localparam addr_t FAR_WRAP  = addr_t'(N_WORDS - M_SHIFT);

    localparam word_t MATRIX_A = 32'h9908_b0df;
    localparam word_t UPPER_MSK = 32'h8000_0000;
    localparam word_t LOWER_MSK = 32'h7fff_ffff;
    localparam word_t TEMPER_B = 32'h9d2c_5680;
    localparam word_t TEMPER_C = 32'hefc6_0000;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_GEN  = 1'b1
    } cmd_t;

    // One access set to the state memory in a cycle.
    typedef struct packed
    {
        logic  we;
        addr_t waddr;
        word_t wdata;
        logic  re;
        addr_t raddr_a;
        addr_t raddr_b;
    } mem_req_t;

    // A finished output word handed to the output stage.
    typedef struct packed
    {
        logic  valid;
        word_t word;
    } gen_t;

    function automatic word_t twist_word(input word_t cur, input word_t nxt,
                                         input word_t far);
        word_t y;
        word_t r;
        y = (cur & UPPER_MSK) | (nxt & LOWER_MSK);
        r = far ^ (y >> 1);
        if (y[0])
        begin
            r = r ^ MATRIX_A;
        end
        return r;
    endfunction

    function automatic word_t temper(input word_t x);
        word_t y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

FILE: rtl/core/mt19937_word_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_word_generator
// MT19937 generator with a state that is loaded word by word.
// ----------------------------------------------------------------------------
// The input channel carries one beat per command. A load beat (command 0)
// writes word_value to state word word_index (an index of 624 or more writes
// nothing) and restarts the word pointer at zero; it gives no result and the
// block is ready again in the next cycle. A generate beat (command 1) gives
// one tempered word on the output channel.
// A generate beat first reads the state memory and then tempers the read
// word into the output register once that register is free.
// After 624 words the next generate beat first twists the state in place,
// one word at a time with a read state and a write state per word, since
// the sequencer never reads and writes the memory at once.
// Reset clears the pointer and the sequencer; the state memory is not
// cleared and must be fully loaded before words are generated.
// The output register holds a finished word while the receiver stalls; the
// block still accepts the next beat, and a generate beat then waits in the
// sequencer until the output register is free.
// ----------------------------------------------------------------------------
module mt19937_word_generator
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [9:0]            word_index,
    input  logic [31:0]           word_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           random_word
);

    mtwg_pkg::mem_req_t req;
    mtwg_pkg::word_t    rd_a;
    mtwg_pkg::word_t    rd_b;
    mtwg_pkg::gen_t     gen;
    mtwg_pkg::addr_t    ptr;
    logic               out_free;
    logic               out_valid_reg, out_valid_next;
    mtwg_pkg::word_t    word_reg, word_next;

    assign out_free = !out_valid_reg || out_ready;

    mtwg_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .word_index (word_index),
        .word_value (word_value),
        .out_free   (out_free),
        .req        (req),
        .rd_a       (rd_a),
        .rd_b       (rd_b),
        .gen        (gen),
        .ptr        (ptr)
    );

    mtwg_state_ram u_ram
    (
        .clk  (clk),
        .req  (req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        if (gen.valid)
        begin
            out_valid_next = 1'b1;
            word_next      = gen.word;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid   = out_valid_reg;
    assign random_word = word_reg;

    // A load beat always restarts the pointer.
    a_load_clears_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command == mtwg_pkg::CMD_LOAD) |=> (ptr == '0))
        else $error("pointer not cleared after a load beat");

    // The pointer never runs past the end of the state.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr <= mtwg_pkg::PTR_END))
        else $error("word pointer out of range");

    // A new word is handed over only when the output register can take it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        gen.valid |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before it was taken");

    // The memory is never written and read in the same cycle.
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |-> !req.re)
        else $error("state memory read and written in one cycle");

endmodule

FILE: rtl/core/mtwg_state_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_state_ram
// State word memory: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module mtwg_state_ram
(
    input  logic               clk,
    input  mtwg_pkg::mem_req_t req,
    output mtwg_pkg::word_t    rd_a,
    output mtwg_pkg::word_t    rd_b
);

    mtwg_pkg::word_t mem [mtwg_pkg::N_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_a <= mem[req.raddr_a];
            rd_b <= mem[req.raddr_b];
        end
    end

endmodule

FILE: rtl/core/mtwg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwg_ctrl
// Sequencer for loads, the in-place twist and word generation.
// ----------------------------------------------------------------------------
module mtwg_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  mtwg_pkg::addr_t    word_index,
    input  mtwg_pkg::word_t    word_value,
    input  logic               out_free,
    output mtwg_pkg::mem_req_t req,
    input  mtwg_pkg::word_t    rd_a,
    input  mtwg_pkg::word_t    rd_b,
    output mtwg_pkg::gen_t     gen,
    output mtwg_pkg::addr_t    ptr
);

    typedef enum logic [5:0]
    {
        S_IDLE    = 6'b000001,
        S_TW_CAP  = 6'b000010,
        S_TW_RD   = 6'b000100,
        S_TW_WR   = 6'b001000,
        S_GEN_RD  = 6'b010000,
        S_GEN_OUT = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    mtwg_pkg::addr_t idx_reg, idx_next;
    mtwg_pkg::addr_t ptr_reg, ptr_next;
    mtwg_pkg::word_t cur_reg, cur_next;
    logic            accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign ptr      = ptr_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        ptr_next    = ptr_reg;
        cur_next    = cur_reg;
        req         = '0;
        gen.valid   = 1'b0;
        gen.word    = mtwg_pkg::temper(rd_a);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == mtwg_pkg::CMD_LOAD)
                    begin
                        req.we    = (word_index < mtwg_pkg::PTR_END);
                        req.waddr = word_index;
                        req.wdata = word_value;
                        ptr_next  = '0;
                    end
                    else if (ptr_reg >= mtwg_pkg::PTR_END)
                    begin
                        // Word 0 is fetched first; it is the current word of step 0.
                        req.re     = 1'b1;
                        req.raddr_a = '0;
                        idx_next   = '0;
                        state_next = S_TW_CAP;
                    end
                    else
                    begin
                        req.re      = 1'b1;
                        req.raddr_a = ptr_reg;
                        state_next  = S_GEN_OUT;
                    end
                end
            end

            S_TW_CAP:
            begin
                cur_next   = rd_a;
                state_next = S_TW_RD;
            end

            S_TW_RD:
            begin
                req.re      = 1'b1;
                req.raddr_a = (idx_reg == mtwg_pkg::LAST_ADDR) ? '0 : idx_reg + 1'b1;
                req.raddr_b = (idx_reg < mtwg_pkg::FAR_WRAP) ?
                              idx_reg + mtwg_pkg::FAR_STEP :
                              idx_reg - mtwg_pkg::FAR_WRAP;
                state_next  = S_TW_WR;
            end

            S_TW_WR:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg;
                req.wdata = mtwg_pkg::twist_word(cur_reg, rd_a, rd_b);
                // The neighbor word read now is the current word of the next step.
                cur_next  = rd_a;
                if (idx_reg == mtwg_pkg::LAST_ADDR)
                begin
                    ptr_next   = '0;
                    state_next = S_GEN_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TW_RD;
                end
            end

            S_GEN_RD:
            begin
                req.re      = 1'b1;
                req.raddr_a = ptr_reg;
                state_next  = S_GEN_OUT;
            end

            S_GEN_OUT:
            begin
                if (out_free)
                begin
                    gen.valid  = 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

FILE: bench/mt19937_word_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_word_generator_tb
// Self-checking bench for the directly loaded MT19937 word generator.
// ----------------------------------------------------------------------------
// The bench loads all 624 state words, then runs directed commands at the
// field extremes and for out-of-range load indexes. It follows with a long
// run of generate beats that forces a full twist, and then a random mix of
// loads and generates. A scoreboard class predicts every tempered word from
// its own copy of the state and compares each output beat in order. Both
// channels idle at random, and once the receiver holds off long enough for
// the block to stall its input.
// ----------------------------------------------------------------------------
module mt19937_word_generator_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int STREAK_GENS  = 630;
    localparam int MIX_ITEMS    = 20;

    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;

    typedef enum int
    {
        RESULT_MATCH,
        RESULT_MISMATCH,
        RESULT_UNEXPECTED
    } check_t;

    // Holds the predicted generator state and the words still owed by the block.
    class mt_scoreboard;
        mtwg_pkg::word_t state_mem [mtwg_pkg::N_WORDS];
        int unsigned     ptr;
        mtwg_pkg::word_t expected_words [$];

        function new();
            foreach (state_mem[i])
            begin
                state_mem[i] = '0;
            end
            ptr = 0;
        endfunction

        function mtwg_pkg::word_t tempered(mtwg_pkg::word_t x);
            mtwg_pkg::word_t v;
            v = x;
            v = v ^ (v >> 11);
            v = v ^ ((v << 7) & mtwg_pkg::TEMPER_B);
            v = v ^ ((v << 15) & mtwg_pkg::TEMPER_C);
            v = v ^ (v >> 18);
            return v;
        endfunction

        function void twist_state();
            mtwg_pkg::word_t y;
            mtwg_pkg::word_t r;
            int unsigned     nxt;
            int unsigned     far;
            for (int unsigned i = 0; i < mtwg_pkg::N_WORDS; i++)
            begin
                nxt = (i + 1) % mtwg_pkg::N_WORDS;
                far = (i + mtwg_pkg::M_SHIFT) % mtwg_pkg::N_WORDS;
                y = (state_mem[i] & mtwg_pkg::UPPER_MSK) |
                    (state_mem[nxt] & mtwg_pkg::LOWER_MSK);
                r = state_mem[far] ^ (y >> 1);
                if (y[0])
                begin
                    r = r ^ mtwg_pkg::MATRIX_A;
                end
                state_mem[i] = r;
            end
        endfunction

        function void note_input(mtwg_pkg::cmd_t cmd, logic [9:0] idx,
                                 mtwg_pkg::word_t val);
            if (cmd == mtwg_pkg::CMD_LOAD)
            begin
                if (idx < mtwg_pkg::N_WORDS)
                begin
                    state_mem[idx] = val;
                end
                ptr = 0;
            end
            else
            begin
                if (ptr >= mtwg_pkg::N_WORDS)
                begin
                    twist_state();
                    ptr = 0;
                end
                expected_words.push_back(tempered(state_mem[ptr]));
                ptr++;
            end
        endfunction

        function check_t check_result(mtwg_pkg::word_t got,
                                      output mtwg_pkg::word_t want);
            want = '0;
            if (expected_words.size() == 0)
            begin
                return RESULT_UNEXPECTED;
            end
            want = expected_words.pop_front();
            return (got === want) ? RESULT_MATCH : RESULT_MISMATCH;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [9:0]  word_index;
    logic [31:0] word_value;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] random_word;

    mt_scoreboard sb;
    int           mismatches = 0;
    int           cycle_count = 0;
    int           hold_requests = 0;
    int           stretch_left [2] = '{0, 0};
    bit           calm_mode [2] = '{1'b0, 1'b0};

    mt19937_word_generator i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .word_index  (word_index),
        .word_value  (word_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_word (random_word)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Each side runs in stretches of random gaps or of none, picked at random per stretch.
    function automatic int draw_gap(int side);
        if (stretch_left[side] == 0)
        begin
            stretch_left[side] = $urandom_range(5, 40);
            calm_mode[side] = ($urandom_range(0, 2) == 0);
        end
        stretch_left[side]--;
        return calm_mode[side] ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_beat(mtwg_pkg::cmd_t cmd, logic [9:0] idx,
                             mtwg_pkg::word_t val);
        int gap;
        gap = draw_gap(SIDE_SEND);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        word_index <= idx;
        word_value <= val;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_input(cmd, idx, val);
    endtask

    task automatic send_generate();
        send_beat(mtwg_pkg::CMD_GEN, 10'($urandom_range(0, 1023)),
                  mtwg_pkg::word_t'($urandom));
    endtask

    always @(posedge clk)
    begin
        check_t          status;
        mtwg_pkg::word_t want;
        if (rst_n === 1'b1 && out_valid && out_ready)
        begin
            status = sb.check_result(random_word, want);
            if (status == RESULT_UNEXPECTED)
            begin
                report_mismatch($sformatf("unexpected random_word %08h", random_word));
            end
            else if (status == RESULT_MISMATCH)
            begin
                report_mismatch($sformatf("random_word %08h, expected %08h",
                                          random_word, want));
            end
        end
    end

    initial
    begin : receiver
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                stall_left = draw_gap(SIDE_RECV);
            end
            if (holds_done != hold_requests)
            begin
                holds_done++;
                stall_left = LONG_HOLD;
            end
            out_ready <= (stall_left == 0);
            if (stall_left > 0)
            begin
                stall_left--;
            end
        end
    end

    initial
    begin : stimulus
        mtwg_pkg::word_t val;
        sb = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = mtwg_pkg::CMD_LOAD;
        word_index = '0;
        word_value = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every state word is loaded before the first generate beat.
        for (int i = 0; i < mtwg_pkg::N_WORDS; i++)
        begin
            case (i)
                0:       val = 32'h8000_0000;
                1:       val = 32'h0000_0000;
                2:       val = 32'hffff_ffff;
                396:     val = 32'h7fff_ffff;
                623:     val = 32'hffff_ffff;
                default: val = $urandom;
            endcase
            send_beat(mtwg_pkg::CMD_LOAD, 10'(i), val);
        end

        // Ignored fields on generate beats take both extremes.
        send_beat(mtwg_pkg::CMD_GEN, 10'd0, 32'h0000_0000);
        send_beat(mtwg_pkg::CMD_GEN, 10'd1023, 32'hffff_ffff);
        send_generate();
        // Out-of-range loads write nothing but still restart the pointer.
        send_beat(mtwg_pkg::CMD_LOAD, 10'd624, 32'hffff_ffff);
        send_generate();
        send_beat(mtwg_pkg::CMD_LOAD, 10'd1023, mtwg_pkg::word_t'($urandom));
        send_generate();
        send_generate();
        send_beat(mtwg_pkg::CMD_LOAD, 10'd0, 32'hffff_ffff);
        send_beat(mtwg_pkg::CMD_LOAD, 10'd623, 32'h0000_0000);
        send_generate();
        send_generate();
        send_beat(mtwg_pkg::CMD_LOAD, 10'd511, 32'h0000_0000);
        send_beat(mtwg_pkg::CMD_LOAD, 10'd512, 32'hffff_ffff);
        send_generate();
        send_beat(mtwg_pkg::CMD_LOAD, 10'd625, 32'h0000_0001);
        send_generate();
        send_generate();

        // A long run of generate beats after a load goes through a full twist.
        // The receiver holds off at its start so the block backs up its input.
        send_beat(mtwg_pkg::CMD_LOAD, 10'($urandom_range(0, mtwg_pkg::N_WORDS - 1)),
                  mtwg_pkg::word_t'($urandom));
        hold_requests++;
        for (int i = 0; i < STREAK_GENS; i++)
        begin
            send_generate();
        end

        for (int i = 0; i < MIX_ITEMS; i++)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                send_beat(mtwg_pkg::CMD_LOAD, 10'($urandom_range(0, 1023)),
                          mtwg_pkg::word_t'($urandom));
            end
            else
            begin
                send_generate();
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
